// ===== rtl/fac_pkg.sv =====
// Package for the formation alignment check: widths, constants, CORDIC table,
// and the command/status structs between controller and datapath. No dependencies.
package fac_pkg;

  localparam int PosW = 24;
  localparam int HeadW = 15;
  localparam int TrigW = 16;
  localparam int CordW = 20;
  localparam int CordSteps = 16;
  localparam int StepW = 4;

  localparam logic signed [HeadW-1:0] HalfTurn = 15'sd12868;
  localparam logic signed [HeadW-1:0] QuarterTurn = 15'sd6434;
  localparam logic [HeadW-1:0] HeadErrMax = 15'd25736;
  localparam logic signed [CordW-1:0] CordGain = 20'sd39797;
  localparam logic signed [TrigW-1:0] Q14One = 16'sd16384;

  localparam logic [PosW-1:0] LatLimitReset = 24'd205;
  localparam logic [PosW-1:0] LonLimitReset = 24'd358;
  localparam logic [HeadW-1:0] HeadLimitReset = 15'd2145;

  typedef enum logic [1:0] {
    CFG_LAT = 2'd0,
    CFG_LON = 2'd1,
    CFG_HEAD = 2'd2
  } cfg_index_t;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_CHECK = 1'b1;

  typedef struct packed {
    logic capture;     // latch input beat
    logic cord_init;   // start CORDIC
    logic cord_step;   // one CORDIC iteration
    logic cord_store;  // write leader trig
    logic mult;        // register products
    logic finish;      // form result into output register
  } fac_cmd_t;

  typedef struct packed {
    logic is_check;
  } fac_status_t;

  function automatic logic signed [CordW-1:0] atan_q16(input logic [StepW-1:0] i);
    logic signed [CordW-1:0] r;
    begin
      case (i)
        4'd0: r = 20'sd51472;
        4'd1: r = 20'sd30386;
        4'd2: r = 20'sd16055;
        4'd3: r = 20'sd8150;
        4'd4: r = 20'sd4091;
        4'd5: r = 20'sd2047;
        4'd6: r = 20'sd1024;
        4'd7: r = 20'sd512;
        4'd8: r = 20'sd256;
        4'd9: r = 20'sd128;
        4'd10: r = 20'sd64;
        4'd11: r = 20'sd32;
        4'd12: r = 20'sd16;
        4'd13: r = 20'sd8;
        4'd14: r = 20'sd4;
        default: r = 20'sd2;
      endcase
      return r;
    end
  endfunction

endpackage

// ===== rtl/fac_ctrl.sv =====
// Controller for the formation alignment check: sequences capture, CORDIC,
// multiply and result stages. Depends on fac_pkg.
module fac_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_fire,
  input  logic                 out_busy,
  input  fac_pkg::fac_status_t status,
  output logic                 in_stall,
  output fac_pkg::fac_cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_INIT  = 6'b000010,
    S_CORD  = 6'b000100,
    S_STORE = 6'b001000,
    S_MULT  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state, state_next;
  logic [fac_pkg::StepW-1:0] step, step_next;

  always_comb begin
    state_next = state;
    step_next = step;
    cmd = '0;
    cmd.capture = in_fire;
    case (state)
      S_IDLE: begin
        if (in_fire) state_next = S_INIT;
      end
      S_INIT: begin
        if (status.is_check) begin
          state_next = S_MULT;
        end else begin
          cmd.cord_init = 1'b1;
          step_next = '0;
          state_next = S_CORD;
        end
      end
      S_CORD: begin
        cmd.cord_step = 1'b1;
        step_next = step + 1'b1;
        if (step == fac_pkg::StepW'(fac_pkg::CordSteps - 1)) state_next = S_STORE;
      end
      S_STORE: begin
        cmd.cord_store = 1'b1;
        state_next = S_DONE;
      end
      S_MULT: begin
        cmd.mult = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= '0;
    end else begin
      state <= state_next;
      step <= step_next;
    end
  end

  a_one_hot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !in_fire) else $error("beat accepted while busy");
  a_finish_once: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> state == S_IDLE) else $error("finish without return to idle");

endmodule

// ===== rtl/fac_dp.sv =====
// Datapath for the formation alignment check: leader store, shared CORDIC,
// rotation multipliers, rounding, limits and result register. Depends on fac_pkg.
module fac_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  fac_pkg::fac_cmd_t           cmd,
  output fac_pkg::fac_status_t        status,
  input  logic                        command,
  input  logic signed [fac_pkg::PosW-1:0]  pos_x,
  input  logic signed [fac_pkg::PosW-1:0]  pos_y,
  input  logic signed [fac_pkg::HeadW-1:0] heading,
  input  logic                        final_follower,
  input  logic [fac_pkg::PosW-1:0]    lat_limit,
  input  logic [fac_pkg::PosW-1:0]    lon_limit,
  input  logic [fac_pkg::HeadW-1:0]   head_limit,
  input  logic                        out_take,
  output logic                        out_valid,
  output logic [fac_pkg::PosW-1:0]    lat_offset,
  output logic [fac_pkg::PosW-1:0]    lon_offset,
  output logic [fac_pkg::HeadW-1:0]   heading_error,
  output logic                        lateral_fail,
  output logic                        longitudinal_fail,
  output logic                        heading_fail,
  output logic                        round_done,
  output logic                        platoon_ready
);

  localparam int PW = fac_pkg::PosW;
  localparam int CW = fac_pkg::CordW;
  localparam int TW = fac_pkg::TrigW;
  localparam int DW = PW + 1;
  localparam int MW = DW + TW;
  localparam int SW = MW + 1;

  // Captured beat.
  logic in_cmd, in_final;
  logic signed [PW-1:0] in_x, in_y;
  logic signed [fac_pkg::HeadW-1:0] in_head;

  // Leader state.
  logic signed [PW-1:0] leader_x, leader_y;
  logic signed [fac_pkg::HeadW-1:0] leader_heading;
  logic signed [TW-1:0] leader_cosine, leader_sine;
  logic round_all_ok;

  // CORDIC.
  logic signed [CW-1:0] cx, cy, cz;
  logic [fac_pkg::StepW-1:0] cstep;
  logic cflip;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_cmd <= command;
      in_final <= final_follower;
      in_x <= pos_x;
      in_y <= pos_y;
      in_head <= heading;
    end
  end

  assign status.is_check = (in_cmd == fac_pkg::CMD_CHECK);

  logic signed [fac_pkg::HeadW:0] fold;
  logic fold_flip;
  always_comb begin
    fold = {in_head[fac_pkg::HeadW-1], in_head};
    fold_flip = 1'b0;
    if (in_head > fac_pkg::QuarterTurn) begin
      fold = fold - 16'(fac_pkg::HalfTurn);
      fold_flip = 1'b1;
    end else if (in_head < -fac_pkg::QuarterTurn) begin
      fold = fold + 16'(fac_pkg::HalfTurn);
      fold_flip = 1'b1;
    end
  end

  logic signed [CW-1:0] xs, ys, at;
  assign xs = cx >>> cstep;
  assign ys = cy >>> cstep;
  assign at = fac_pkg::atan_q16(cstep);

  function automatic logic signed [TW-1:0] round_q14(input logic signed [CW-1:0] v,
                                                     input logic neg);
    logic signed [CW-1:0] r;
    logic signed [TW-1:0] c;
    begin
      r = (v + CW'(2)) >>> 2;
      if (r > CW'(fac_pkg::Q14One)) c = fac_pkg::Q14One;
      else if (r < -CW'(fac_pkg::Q14One)) c = -fac_pkg::Q14One;
      else c = r[TW-1:0];
      return neg ? -c : c;
    end
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.cord_init) begin
      cx <= fac_pkg::CordGain;
      cy <= '0;
      cz <= CW'(fold) <<< 4;
      cflip <= fold_flip;
      cstep <= '0;
    end else if (cmd.cord_step) begin
      if (!cz[CW-1]) begin
        cx <= cx - ys; cy <= cy + xs; cz <= cz - at;
      end else begin
        cx <= cx + ys; cy <= cy - xs; cz <= cz + at;
      end
      cstep <= cstep + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leader_x <= '0;
      leader_y <= '0;
      leader_heading <= '0;
      leader_cosine <= fac_pkg::Q14One;
      leader_sine <= '0;
    end else if (cmd.cord_store) begin
      leader_x <= in_x;
      leader_y <= in_y;
      leader_heading <= in_head;
      leader_cosine <= round_q14(cx, cflip);
      leader_sine <= round_q14(cy, cflip);
    end
  end

  // Rotation products, registered before the sums.
  logic signed [DW-1:0] dx, dy;
  logic signed [MW-1:0] p_sx, p_cy, p_cx, p_sy;
  logic signed [fac_pkg::HeadW:0] hdiff;
  assign dx = DW'(in_x) - DW'(leader_x);
  assign dy = DW'(in_y) - DW'(leader_y);

  always_ff @(posedge clk) begin
    if (cmd.mult) begin
      p_sx <= MW'(leader_sine) * MW'(dx);
      p_cy <= MW'(leader_cosine) * MW'(dy);
      p_cx <= MW'(leader_cosine) * MW'(dx);
      p_sy <= MW'(leader_sine) * MW'(dy);
      hdiff <= (fac_pkg::HeadW+1)'(in_head) - (fac_pkg::HeadW+1)'(leader_heading);
    end
  end

  function automatic logic [SW-1:0] mag_q8(input logic signed [SW-1:0] v);
    logic [SW-1:0] m;
    begin
      m = v[SW-1] ? SW'(-v) : SW'(v);
      return (m + SW'(8192)) >> 14;
    end
  endfunction

  logic signed [SW-1:0] lat_raw, lon_raw;
  logic [SW-1:0] lat, lon;
  logic [fac_pkg::HeadW:0] herr;
  logic lf, gf, hf;
  assign lat_raw = SW'(p_cy) - SW'(p_sx);
  assign lon_raw = SW'(p_cx) + SW'(p_sy);
  assign lat = mag_q8(lat_raw);
  assign lon = mag_q8(lon_raw);
  assign herr = hdiff[fac_pkg::HeadW] ? (fac_pkg::HeadW+1)'(-hdiff)
                                      : (fac_pkg::HeadW+1)'(hdiff);
  assign lf = lat > SW'(lat_limit);
  assign gf = lon > SW'(lon_limit);
  assign hf = herr > (fac_pkg::HeadW+1)'(head_limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      round_all_ok <= 1'b1;
    end else if (cmd.finish && in_cmd == fac_pkg::CMD_CHECK) begin
      if (in_final) round_all_ok <= 1'b1;
      else if (lf || gf || hf) round_all_ok <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (in_cmd == fac_pkg::CMD_LOAD) begin
        lat_offset <= '0;
        lon_offset <= '0;
        heading_error <= '0;
        lateral_fail <= 1'b0;
        longitudinal_fail <= 1'b0;
        heading_fail <= 1'b0;
        round_done <= 1'b0;
        platoon_ready <= 1'b0;
      end else begin
        lat_offset <= (lat > SW'({PW{1'b1}})) ? {PW{1'b1}} : lat[PW-1:0];
        lon_offset <= (lon > SW'({PW{1'b1}})) ? {PW{1'b1}} : lon[PW-1:0];
        heading_error <= (herr > (fac_pkg::HeadW+1)'(fac_pkg::HeadErrMax))
                         ? fac_pkg::HeadErrMax : herr[fac_pkg::HeadW-1:0];
        lateral_fail <= lf;
        longitudinal_fail <= gf;
        heading_fail <= hf;
        round_done <= in_final;
        platoon_ready <= in_final && round_all_ok && !(lf || gf || hf);
      end
    end
  end

  a_ready_needs_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && platoon_ready |-> round_done) else $error("ready outside round end");
  a_trig_bound: assert property (@(posedge clk) disable iff (rst)
    leader_cosine <= fac_pkg::Q14One && leader_cosine >= -fac_pkg::Q14One)
    else $error("cosine out of range");
  a_round_reset: assert property (@(posedge clk) disable iff (rst)
    cmd.finish && in_cmd == fac_pkg::CMD_CHECK && in_final |=> round_all_ok)
    else $error("round flag not restored");

endmodule

// ===== rtl/formation_alignment_check_core.sv =====
// Top level of the formation alignment check: ports, limit registers and the
// controller/datapath pair. Depends on fac_pkg, fac_ctrl and fac_dp.
//
// A follower check passes through capture, the init state, multiply and result
// before its result is in the output register. A leader load passes through
// capture, init, the 16 iterations of the shared CORDIC unit, store and result.
// in_stall stays high until the result is in the output register, so no new
// beat is taken before the last one's result is there. A result held by
// out_stall keeps the next beat waiting for as long as the stall lasts. Limit
// registers reset to 0.8 m, 1.4 m and pi/6.
module formation_alignment_check_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [1:0]                       cfg_index,
  input  logic [fac_pkg::PosW-1:0]         cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             command,
  input  logic signed [fac_pkg::PosW-1:0]  pos_x,
  input  logic signed [fac_pkg::PosW-1:0]  pos_y,
  input  logic signed [fac_pkg::HeadW-1:0] heading,
  input  logic                             final_follower,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [fac_pkg::PosW-1:0]         lat_offset,
  output logic [fac_pkg::PosW-1:0]         lon_offset,
  output logic [fac_pkg::HeadW-1:0]        heading_error,
  output logic                             lateral_fail,
  output logic                             longitudinal_fail,
  output logic                             heading_fail,
  output logic                             round_done,
  output logic                             platoon_ready
);

  logic [fac_pkg::PosW-1:0] lat_limit, lon_limit;
  logic [fac_pkg::HeadW-1:0] head_limit;
  fac_pkg::fac_cmd_t cmd;
  fac_pkg::fac_status_t status;
  logic stall_i, in_fire;

  assign cfg_ready = 1'b1;
  assign in_stall = stall_i;
  assign in_fire = in_valid && !stall_i;

  always_ff @(posedge clk) begin
    if (rst) begin
      lat_limit <= fac_pkg::LatLimitReset;
      lon_limit <= fac_pkg::LonLimitReset;
      head_limit <= fac_pkg::HeadLimitReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        fac_pkg::CFG_LAT: lat_limit <= cfg_data;
        fac_pkg::CFG_LON: lon_limit <= cfg_data;
        fac_pkg::CFG_HEAD: head_limit <= cfg_data[fac_pkg::HeadW-1:0];
        default: ;
      endcase
    end
  end

  fac_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_busy(out_valid && out_stall),
    .status(status), .in_stall(stall_i), .cmd(cmd)
  );

  fac_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .command(command), .pos_x(pos_x), .pos_y(pos_y), .heading(heading),
    .final_follower(final_follower),
    .lat_limit(lat_limit), .lon_limit(lon_limit), .head_limit(head_limit),
    .out_take(out_valid && !out_stall), .out_valid(out_valid),
    .lat_offset(lat_offset), .lon_offset(lon_offset),
    .heading_error(heading_error), .lateral_fail(lateral_fail),
    .longitudinal_fail(longitudinal_fail), .heading_fail(heading_fail),
    .round_done(round_done), .platoon_ready(platoon_ready)
  );

endmodule

// ===== tb/sv/formation_alignment_check_core_tb.sv =====
`timescale 1ns / 100ps
// Testbench for formation_alignment_check_core: directed and random leader/follower
// beats, checked against an in-bench pose-alignment predictor. Depends on fac_pkg and formation_alignment_check_core.
module formation_alignment_check_core_tb;

  localparam int PW = fac_pkg::PosW;
  localparam int HW = fac_pkg::HeadW;

  typedef struct {
    logic [PW-1:0]  lat;
    logic [PW-1:0]  lon;
    logic [HW-1:0]  herr;
    logic           lat_f;
    logic           lon_f;
    logic           head_f;
    logic           done;
    logic           ready;
  } pose_check_t;

  localparam int StallLimit = 5000;
  localparam longint AtanTab[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                     256, 128, 64, 32, 16, 8, 4, 2};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [PW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic command = fac_pkg::CMD_LOAD;
  logic signed [PW-1:0] pos_x = '0;
  logic signed [PW-1:0] pos_y = '0;
  logic signed [HW-1:0] heading = '0;
  logic final_follower = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [PW-1:0] lat_offset;
  logic [PW-1:0] lon_offset;
  logic [HW-1:0] heading_error;
  logic lateral_fail;
  logic longitudinal_fail;
  logic heading_fail;
  logic round_done;
  logic platoon_ready;

  // Predictor state.
  longint lat_limit, lon_limit, head_limit;
  longint ldr_x, ldr_y, ldr_head, ldr_cos, ldr_sin;
  bit all_ok;

  pose_check_t pending_checks[$];
  int errors = 0;
  int idle_cycles = 0;
  int stall_mode = 0;

  formation_alignment_check_core u_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void heading_trig(input longint ang, output longint c,
                                       output longint s);
    bit flip;
    longint x, y, z, xs, ys;
    flip = 1'b0;
    x = longint'(fac_pkg::CordGain);
    y = 0;
    if (ang > longint'(fac_pkg::QuarterTurn)) begin
      ang -= longint'(fac_pkg::HalfTurn);
      flip = 1'b1;
    end else if (ang < -longint'(fac_pkg::QuarterTurn)) begin
      ang += longint'(fac_pkg::HalfTurn);
      flip = 1'b1;
    end
    z = ang * 16;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= AtanTab[i];
      end else begin
        x += ys; y -= xs; z += AtanTab[i];
      end
    end
    c = (x + 2) >>> 2;
    s = (y + 2) >>> 2;
    if (c > 16384) c = 16384;
    if (c < -16384) c = -16384;
    if (s > 16384) s = 16384;
    if (s < -16384) s = -16384;
    if (flip) begin
      c = -c;
      s = -s;
    end
  endfunction

  function automatic longint round_q8(input longint v);
    longint m;
    m = (v < 0) ? -v : v;
    return (m + 8192) >>> 14;
  endfunction

  function automatic pose_check_t predict_alignment(input logic cmd,
      input longint px, input longint py, input longint hd, input logic last);
    pose_check_t r;
    longint dx, dy, lat, lon, herr;
    r = '{default: '0};
    if (cmd == fac_pkg::CMD_LOAD) begin
      ldr_x = px;
      ldr_y = py;
      ldr_head = hd;
      heading_trig(hd, ldr_cos, ldr_sin);
      return r;
    end
    dx = px - ldr_x;
    dy = py - ldr_y;
    lat = round_q8(-ldr_sin * dx + ldr_cos * dy);
    lon = round_q8(ldr_cos * dx + ldr_sin * dy);
    herr = hd - ldr_head;
    if (herr < 0) herr = -herr;
    r.lat_f = lat > lat_limit;
    r.lon_f = lon > lon_limit;
    r.head_f = herr > head_limit;
    if (r.lat_f || r.lon_f || r.head_f) all_ok = 1'b0;
    r.lat = (lat > 64'hFFFFFF) ? 24'hFFFFFF : lat[PW-1:0];
    r.lon = (lon > 64'hFFFFFF) ? 24'hFFFFFF : lon[PW-1:0];
    r.herr = (herr > longint'(fac_pkg::HeadErrMax)) ? fac_pkg::HeadErrMax : herr[HW-1:0];
    if (last) begin
      r.done = 1'b1;
      r.ready = all_ok;
      all_ok = 1'b1;
    end
    return r;
  endfunction

  // Sends one beat; a gap of zero keeps valid high into the next beat.
  task automatic send_pose(input logic cmd, input logic signed [PW-1:0] px,
      input logic signed [PW-1:0] py, input logic signed [HW-1:0] hd,
      input logic last, input int gap);
    in_valid <= 1'b1;
    command <= cmd;
    pos_x <= px;
    pos_y <= py;
    heading <= hd;
    final_follower <= last;
    do @(posedge clk); while (in_stall);
    pending_checks.push_back(predict_alignment(cmd, longint'(px), longint'(py),
                                               longint'(hd), last));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_checks.size() == 0);
    // Leave a quiet spell before the limits are rewritten.
    repeat (30) @(posedge clk);
  endtask

  task automatic write_limit(input fac_pkg::cfg_index_t idx, input logic [PW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      fac_pkg::CFG_LAT:  lat_limit = longint'(val);
      fac_pkg::CFG_LON:  lon_limit = longint'(val);
      fac_pkg::CFG_HEAD: head_limit = longint'(val[HW-1:0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_limits(input logic [PW-1:0] la, input logic [PW-1:0] lo,
                            input logic [PW-1:0] hd);
    drain();
    write_limit(fac_pkg::CFG_LAT, la);
    write_limit(fac_pkg::CFG_LON, lo);
    write_limit(fac_pkg::CFG_HEAD, hd);
  endtask

  task automatic test_directed();
    send_pose(fac_pkg::CMD_CHECK, 24'sd100, -24'sd50, 15'sd300, 1'b1, 0);
    send_pose(fac_pkg::CMD_LOAD, 24'sd0, 24'sd0, 15'sd12868, 1'b1, 2);
    send_pose(fac_pkg::CMD_CHECK, 24'sd300, 24'sd200, 15'sd12000, 1'b0, 0);
    send_pose(fac_pkg::CMD_LOAD, 24'sh7FFFFF, 24'sh800000, 15'sh4000, 1'b0, 0);
    send_pose(fac_pkg::CMD_CHECK, 24'sh800000, 24'sh7FFFFF, 15'sd16383, 1'b0, 1);
    send_pose(fac_pkg::CMD_CHECK, 24'sh7FFFFF, 24'sh800000, 15'sh4000, 1'b1, 0);
    send_pose(fac_pkg::CMD_LOAD, -24'sd1000, 24'sd2000, 15'sd16383, 1'b0, 0);
    send_pose(fac_pkg::CMD_CHECK, -24'sd1000, 24'sd2000, 15'sh4000, 1'b0, 0);
    send_pose(fac_pkg::CMD_LOAD, 24'sd5, 24'sd5, 15'sd6434, 1'b0, 0);
    send_pose(fac_pkg::CMD_CHECK, 24'sd5, 24'sd210, 15'sd6434, 1'b0, 0);
    send_pose(fac_pkg::CMD_LOAD, 24'sd5, 24'sd5, -15'sd6435, 1'b0, 3);
    send_pose(fac_pkg::CMD_CHECK, 24'sd100, 24'sd5, -15'sd6000, 1'b1, 0);
    send_pose(fac_pkg::CMD_LOAD, 24'sd0, 24'sd0, 15'sd0, 1'b0, 0);
    send_pose(fac_pkg::CMD_CHECK, 24'sd358, 24'sd205, 15'sd2145, 1'b1, 0);
    send_pose(fac_pkg::CMD_CHECK, 24'sd359, 24'sd206, 15'sd2146, 1'b1, 0);
  endtask

  task automatic test_limits();
    set_limits(24'd0, 24'd0, 24'd0);
    send_pose(fac_pkg::CMD_CHECK, 24'sd0, 24'sd0, 15'sd0, 1'b1, 0);
    send_pose(fac_pkg::CMD_CHECK, 24'sd1, 24'sd1, 15'sd1, 1'b1, 0);
    set_limits(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_pose(fac_pkg::CMD_CHECK, 24'sh7FFFFF, 24'sh800000, 15'sh4000, 1'b1, 0);
    drain();
    // Index 3 addresses no register and must leave the limits alone.
    write_limit(fac_pkg::cfg_index_t'(2'd3), 24'd7);
    send_pose(fac_pkg::CMD_CHECK, 24'sd2, 24'sd2, 15'sd9, 1'b1, 0);
    set_limits(24'd205, 24'd358, 24'd25736);
  endtask

  task automatic random_rounds(input int beats);
    int sent, n, gap, burst;
    logic signed [PW-1:0] lx, ly, fx, fy;
    logic signed [HW-1:0] lh, fh;
    sent = 0;
    burst = 0;
    while (sent < beats) begin
      lx = PW'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4000) - 2000);
      ly = PW'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4000) - 2000);
      lh = HW'(($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 25736) - 12868);
      n = $urandom_range(1, 6);
      for (int k = 0; k <= n; k++) begin
        if (burst == 0) begin
          burst = $urandom_range(1, 12);
          gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else gap = 0;
        burst--;
        if (k == 0) begin
          send_pose(fac_pkg::CMD_LOAD, lx, ly, lh, 1'($urandom), gap);
        end else begin
          if ($urandom_range(0, 9) == 0) begin
            fx = PW'($urandom);
            fy = PW'($urandom);
            fh = HW'($urandom);
          end else begin
            fx = PW'(lx + $signed($urandom_range(0, 800)) - 400);
            fy = PW'(ly + $signed($urandom_range(0, 800)) - 400);
            fh = HW'(lh + $signed($urandom_range(0, 5000)) - 2500);
          end
          send_pose(fac_pkg::CMD_CHECK, fx, fy, fh,
                    (k == n) ? 1'b1 : ($urandom_range(0, 7) == 0), gap);
        end
        sent++;
      end
    end
  endtask

  task automatic test_random();
    random_rounds(350);
    set_limits(PW'($urandom_range(0, 600)), PW'($urandom_range(0, 800)),
               PW'($urandom_range(0, 4000)));
    random_rounds(350);
    set_limits(PW'($urandom_range(100, 300)), PW'($urandom_range(200, 500)),
               PW'($urandom_range(1000, 3000)));
    random_rounds(350);
  endtask

  // Receiver stall pattern: switches among free flow, light and heavy stalling.
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  always @(posedge clk) begin : check_results
    pose_check_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_checks.size() == 0) begin
        $display("%0t: unexpected result beat", $realtime);
        errors++;
      end else begin
        e = pending_checks.pop_front();
        if (lat_offset !== e.lat) begin
          $display("%0t: lat_offset expected %0d actual %0d", $realtime, e.lat,
                   lat_offset);
          errors++;
        end
        if (lon_offset !== e.lon) begin
          $display("%0t: lon_offset expected %0d actual %0d", $realtime, e.lon,
                   lon_offset);
          errors++;
        end
        if (heading_error !== e.herr) begin
          $display("%0t: heading_error expected %0d actual %0d", $realtime, e.herr,
                   heading_error);
          errors++;
        end
        if (lateral_fail !== e.lat_f) begin
          $display("%0t: lateral_fail expected %0b actual %0b", $realtime, e.lat_f,
                   lateral_fail);
          errors++;
        end
        if (longitudinal_fail !== e.lon_f) begin
          $display("%0t: longitudinal_fail expected %0b actual %0b", $realtime, e.lon_f,
                   longitudinal_fail);
          errors++;
        end
        if (heading_fail !== e.head_f) begin
          $display("%0t: heading_fail expected %0b actual %0b", $realtime, e.head_f,
                   heading_fail);
          errors++;
        end
        if (round_done !== e.done) begin
          $display("%0t: round_done expected %0b actual %0b", $realtime, e.done,
                   round_done);
          errors++;
        end
        if (platoon_ready !== e.ready) begin
          $display("%0t: platoon_ready expected %0b actual %0b", $realtime, e.ready,
                   platoon_ready);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles in which no beat moves on any channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("%0t: no progress", $realtime);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    lat_limit = longint'(fac_pkg::LatLimitReset);
    lon_limit = longint'(fac_pkg::LonLimitReset);
    head_limit = longint'(fac_pkg::HeadLimitReset);
    ldr_x = 0;
    ldr_y = 0;
    ldr_head = 0;
    ldr_cos = 16384;
    ldr_sin = 0;
    all_ok = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_limits();
    test_random();
    drain();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
